// ===== src/mer_pkg.sv =====
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by mer_cfg_regs, mer_ctrl, mer_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

    localparam int RADIUS_BITS   = 10;
    localparam int COORD_BITS    = 12;
    localparam int CFG_DATA_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int CFG_IDX_BITS  = 2;

    localparam int X_BITS   = RADIUS_BITS + 1;
    localparam int Y_BITS   = RADIUS_BITS + 2;
    localparam int SQ_BITS  = 2 * RADIUS_BITS;
    localparam int TX_BITS  = X_BITS + 1;
    localparam int TX2_BITS = 2 * TX_BITS;
    localparam int Y2_BITS  = 2 * Y_BITS;
    localparam int RR_BITS  = 2 * SQ_BITS;
    localparam int PA_BITS  = SQ_BITS + TX2_BITS;
    localparam int PB_BITS  = SQ_BITS + Y2_BITS;
    localparam int DEC_BITS = 48;
    localparam int PIX_BITS = 14;

    localparam logic [COORD_BITS-1:0]  CENTER_X_RESET = COORD_BITS'(400);
    localparam logic [COORD_BITS-1:0]  CENTER_Y_RESET = COORD_BITS'(400);
    localparam logic [RADIUS_BITS-1:0] RADIUS_X_RESET = RADIUS_BITS'(250);
    localparam logic [RADIUS_BITS-1:0] RADIUS_Y_RESET = RADIUS_BITS'(180);

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [RADIUS_BITS-1:0] radius_x;
        logic [RADIUS_BITS-1:0] radius_y;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_MULT,
        ST_UPDATE,
        ST_SQUARE2,
        ST_MULT2,
        ST_SWITCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic mult;
        logic update;
        logic square2;
        logic mult2;
        logic switch_dec;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic short_item;
        logic need_switch;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/mer_cfg_regs.sv =====
// Configuration register bank: center and radii, written through a plain write port.
// Depends on mer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mer_cfg_regs
    import mer_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: cfg_next.center_x = cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y: cfg_next.center_y = cfg_data[COORD_BITS-1:0];
                REG_RADIUS_X: cfg_next.radius_x = cfg_data[RADIUS_BITS-1:0];
                REG_RADIUS_Y: cfg_next.radius_y = cfg_data[RADIUS_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= CENTER_X_RESET;
            cfg_reg.center_y <= CENTER_Y_RESET;
            cfg_reg.radius_x <= RADIUS_X_RESET;
            cfg_reg.radius_y <= RADIUS_Y_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/mer_ctrl.sv =====
// Sequencer for one word: squares, products, decision update, optional region switch.
// Depends on mer_pkg; drives mer_datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl
    import mer_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.short_item ? ST_DONE : ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = stat.need_switch ? ST_SQUARE2 : ST_DONE;
            end
            ST_SQUARE2:
            begin
                cmd.square2 = 1'b1;
                state_next  = ST_MULT2;
            end
            ST_MULT2:
            begin
                cmd.mult2  = 1'b1;
                state_next = ST_SWITCH;
            end
            ST_SWITCH:
            begin
                cmd.switch_dec = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register can take the word
                cmd.commit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mer_datapath.sv =====
// Datapath: walk state, squared radii, shared product registers, decision update
// and the output register. Depends on mer_pkg; sequenced by mer_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mer_datapath
    import mer_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cfg_t                        cfg,
    input  wire logic                        restart,
    input  wire cmd_t                        cmd,
    output stat_t                            stat,
    input  wire logic                        result_ready,
    output logic                             result_valid,
    output logic signed [PIX_BITS-1:0]       pixel_a_x,
    output logic signed [PIX_BITS-1:0]       pixel_a_y,
    output logic signed [PIX_BITS-1:0]       pixel_b_x,
    output logic signed [PIX_BITS-1:0]       pixel_b_y,
    output logic signed [PIX_BITS-1:0]       pixel_c_x,
    output logic signed [PIX_BITS-1:0]       pixel_c_y,
    output logic signed [PIX_BITS-1:0]       pixel_d_x,
    output logic signed [PIX_BITS-1:0]       pixel_d_y,
    output logic                             point_valid,
    output logic                             last_point
);

    // walk state
    logic [X_BITS-1:0]   x_reg;
    logic [Y_BITS-1:0]   y_reg;
    logic [DEC_BITS-1:0] d_reg;
    logic                region2_reg;
    logic                finished_reg;

    // per-word working registers
    logic                restart_reg;
    logic [SQ_BITS-1:0]  rx2_reg;
    logic [SQ_BITS-1:0]  ry2_reg;
    logic [X_BITS-1:0]   xn_reg;
    logic [Y_BITS-1:0]   yn_reg;
    logic                ta_reg;
    logic                tb_reg;
    logic [PA_BITS-1:0]  pa_reg;
    logic [PB_BITS-1:0]  pb_reg;
    logic [TX2_BITS-1:0] tx2_reg;
    logic [Y2_BITS-1:0]  ym2_reg;
    logic [RR_BITS-1:0]  rr_reg;
    logic [DEC_BITS-1:0] dn_reg;
    logic                r2n_reg;
    logic                result_valid_reg;

    logic signed [PIX_BITS-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic signed [PIX_BITS-1:0] pcx_reg, pcy_reg, pdx_reg, pdy_reg;
    logic                       point_valid_reg;
    logic                       last_point_reg;

    // combinational
    logic [SQ_BITS-1:0]  rx2_c;
    logic [SQ_BITS-1:0]  ry2_c;
    logic                neg_c;
    logic                nonpos_c;
    logic [X_BITS-1:0]   xn_c;
    logic [Y_BITS-1:0]   yn_c;
    logic                ta_c;
    logic                tb_c;
    logic [TX2_BITS-1:0] op_a;
    logic [Y2_BITS-1:0]  op_b;
    logic [PA_BITS-1:0]  prod_a;
    logic [PB_BITS-1:0]  prod_b;
    logic [TX_BITS-1:0]  tx_c;
    logic [Y_BITS-1:0]   ym_c;
    logic [TX2_BITS-1:0] tx2_c;
    logic [Y2_BITS-1:0]  ym2_c;
    logic [RR_BITS-1:0]  rr_c;
    logic [DEC_BITS-1:0] term_a;
    logic [DEC_BITS-1:0] term_b;
    logic [DEC_BITS-1:0] base_c;
    logic [DEC_BITS-1:0] bias_c;
    logic [DEC_BITS-1:0] upd_c;
    logic [DEC_BITS-1:0] sw_c;
    logic                less_c;
    logic                need_switch_c;
    logic                out_free_c;
    logic [PIX_BITS-1:0] cx_plus, cx_minus, cy_plus, cy_minus;

    assign rx2_c = cfg.radius_x * cfg.radius_x;
    assign ry2_c = cfg.radius_y * cfg.radius_y;

    // next point of the walk
    always_comb
    begin
        neg_c    = d_reg[DEC_BITS-1];
        nonpos_c = neg_c || (d_reg == '0);
        if (restart_reg)
        begin
            xn_c = '0;
            yn_c = Y_BITS'(cfg.radius_y);
            ta_c = 1'b0;
            tb_c = 1'b1;
        end
        else if (!region2_reg)
        begin
            xn_c = x_reg + X_BITS'(1);
            yn_c = neg_c ? y_reg : (y_reg - Y_BITS'(1));
            ta_c = 1'b1;
            tb_c = !neg_c;
        end
        else
        begin
            xn_c = nonpos_c ? (x_reg + X_BITS'(1)) : x_reg;
            yn_c = y_reg - Y_BITS'(1);
            ta_c = nonpos_c;
            tb_c = 1'b1;
        end
    end

    // shared product pair: ry2*x, rx2*y for the step, ry2*tx^2, rx2*ym^2 for the switch
    assign op_a   = cmd.mult2 ? tx2_reg : TX2_BITS'(xn_c);
    assign op_b   = cmd.mult2 ? ym2_reg : Y2_BITS'(yn_c);
    assign prod_a = ry2_reg * op_a;
    assign prod_b = rx2_reg * op_b;

    assign tx_c  = {xn_reg, 1'b1};
    assign ym_c  = (yn_reg != '0) ? (yn_reg - Y_BITS'(1)) : Y_BITS'(1);
    assign tx2_c = tx_c * tx_c;
    assign ym2_c = ym_c * ym_c;
    assign rr_c  = rx2_reg * ry2_reg;

    // decision update, scaled by 4
    always_comb
    begin
        term_a = ta_reg ? (DEC_BITS'(pa_reg) << 3) : '0;
        if (!tb_reg)
        begin
            term_b = '0;
        end
        else if (restart_reg)
        begin
            term_b = DEC_BITS'(pb_reg) << 2;
        end
        else
        begin
            term_b = DEC_BITS'(pb_reg) << 3;
        end
        if (restart_reg)
        begin
            base_c = '0;
            bias_c = (DEC_BITS'(ry2_reg) << 2) + DEC_BITS'(rx2_reg);
        end
        else if (region2_reg)
        begin
            base_c = d_reg;
            bias_c = DEC_BITS'(rx2_reg) << 2;
        end
        else
        begin
            base_c = d_reg;
            bias_c = DEC_BITS'(ry2_reg) << 2;
        end
        upd_c = base_c + term_a - term_b + bias_c;
        sw_c  = DEC_BITS'(pa_reg) + (DEC_BITS'(pb_reg) << 2) - (DEC_BITS'(rr_reg) << 2);
    end

    assign less_c        = pa_reg < PA_BITS'(pb_reg);
    assign need_switch_c = !restart_reg && !region2_reg && !less_c;
    assign out_free_c    = !result_valid_reg || result_ready;

    assign stat.short_item  = !restart && (finished_reg || (y_reg == '0));
    assign stat.need_switch = need_switch_c;
    assign stat.out_free    = out_free_c;

    assign cx_plus  = PIX_BITS'(cfg.center_x) + PIX_BITS'(x_reg);
    assign cx_minus = PIX_BITS'(cfg.center_x) - PIX_BITS'(x_reg);
    assign cy_plus  = PIX_BITS'(cfg.center_y) + PIX_BITS'(y_reg);
    assign cy_minus = PIX_BITS'(cfg.center_y) - PIX_BITS'(y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            restart_reg <= restart;
        end
        if (cmd.square)
        begin
            rx2_reg <= rx2_c;
            ry2_reg <= ry2_c;
        end
        if (cmd.mult)
        begin
            xn_reg <= xn_c;
            yn_reg <= yn_c;
            ta_reg <= ta_c;
            tb_reg <= tb_c;
        end
        if (cmd.mult || cmd.mult2)
        begin
            pa_reg <= prod_a;
            pb_reg <= prod_b;
        end
        if (cmd.update)
        begin
            dn_reg  <= upd_c;
            r2n_reg <= !restart_reg && (region2_reg || !less_c);
        end
        if (cmd.square2)
        begin
            tx2_reg <= tx2_c;
            ym2_reg <= ym2_c;
            rr_reg  <= rr_c;
        end
        if (cmd.switch_dec)
        begin
            dn_reg <= sw_c;
        end
        if (cmd.commit)
        begin
            if (restart_reg || finished_reg)
            begin
                pax_reg         <= '0;
                pay_reg         <= '0;
                pbx_reg         <= '0;
                pby_reg         <= '0;
                pcx_reg         <= '0;
                pcy_reg         <= '0;
                pdx_reg         <= '0;
                pdy_reg         <= '0;
                point_valid_reg <= 1'b0;
                last_point_reg  <= 1'b0;
            end
            else
            begin
                pax_reg         <= cx_plus;
                pay_reg         <= cy_plus;
                pbx_reg         <= cx_minus;
                pby_reg         <= cy_plus;
                pcx_reg         <= cx_minus;
                pcy_reg         <= cy_minus;
                pdx_reg         <= cx_plus;
                pdy_reg         <= cy_minus;
                point_valid_reg <= 1'b1;
                last_point_reg  <= (y_reg == '0);
            end
        end
    end

    // walk state and output valid carry reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg            <= '0;
            y_reg            <= '0;
            d_reg            <= '0;
            region2_reg      <= 1'b0;
            finished_reg     <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                result_valid_reg <= 1'b1;
                if (restart_reg)
                begin
                    x_reg        <= xn_reg;
                    y_reg        <= yn_reg;
                    d_reg        <= dn_reg;
                    region2_reg  <= 1'b0;
                    finished_reg <= 1'b0;
                end
                else if (!finished_reg)
                begin
                    if (y_reg == '0)
                    begin
                        finished_reg <= 1'b1;
                    end
                    else
                    begin
                        x_reg       <= xn_reg;
                        y_reg       <= yn_reg;
                        d_reg       <= dn_reg;
                        region2_reg <= r2n_reg;
                    end
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_a_x    = pax_reg;
    assign pixel_a_y    = pay_reg;
    assign pixel_b_x    = pbx_reg;
    assign pixel_b_y    = pby_reg;
    assign pixel_c_x    = pcx_reg;
    assign pixel_c_y    = pcy_reg;
    assign pixel_d_x    = pdx_reg;
    assign pixel_d_y    = pdy_reg;
    assign point_valid  = point_valid_reg;
    assign last_point   = last_point_reg;

endmodule

`default_nettype wire

// ===== src/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer: config bank, sequencer and datapath.
// Depends on mer_pkg, mer_cfg_regs, mer_ctrl and mer_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Midpoint ellipse rasterizer. Program center_x, center_y, radius_x and radius_y
// through the write port (index 0..3, taken on any edge with cfg_we high), then send
// one input word with restart=1 to load the start point (0, radius_y), followed by
// words with restart=0. Each step word returns the four symmetric pixels of the current
// point (point_valid=1) and advances the walk; last_point marks the point with y=0 and
// later steps return an all-zero word with point_valid=0, as does every restart word.
// One word is in work at a time. A restart or ordinary step passes through accept, radius
// squares, product pair, decision update and result; a step that crosses into region 2
// adds a second squaring and product pass and a switch step, which recompute the region-2
// decision value before its result. Finished and last-point steps go from accept
// straight to result. The product pair (one multiplier per axis) is shared by the step
// and the region switch. A result waits in the output register while the next word is
// accepted; the block stalls only in its result state if that register is still full.
// There is no clearing pass after reset.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input word channel
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire logic                     restart,
    // result word channel
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic signed [PIX_BITS-1:0]    pixel_a_x,
    output logic signed [PIX_BITS-1:0]    pixel_a_y,
    output logic signed [PIX_BITS-1:0]    pixel_b_x,
    output logic signed [PIX_BITS-1:0]    pixel_b_y,
    output logic signed [PIX_BITS-1:0]    pixel_c_x,
    output logic signed [PIX_BITS-1:0]    pixel_c_y,
    output logic signed [PIX_BITS-1:0]    pixel_d_x,
    output logic signed [PIX_BITS-1:0]    pixel_d_y,
    output logic                          point_valid,
    output logic                          last_point,
    // configuration write port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // register bank: values apply to every following word
    mer_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept in idle, step through the phases, commit on a free output
    mer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: walk state, decision arithmetic and the output register
    mer_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .restart      (restart),
        .cmd          (cmd),
        .stat         (stat),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .pixel_a_x    (pixel_a_x),
        .pixel_a_y    (pixel_a_y),
        .pixel_b_x    (pixel_b_x),
        .pixel_b_y    (pixel_b_y),
        .pixel_c_x    (pixel_c_x),
        .pixel_c_y    (pixel_c_y),
        .pixel_d_x    (pixel_d_x),
        .pixel_d_y    (pixel_d_y),
        .point_valid  (point_valid),
        .last_point   (last_point)
    );

endmodule

`default_nettype wire
